// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define SLSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slsm assertion failed");

// clocked assertion that also holds during reset
`define SLSM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("slsm assertion failed");

`endif

// ===== hw/rtl/slsm_pkg.sv =====
// types and constants of the link session loss monitor
package slsm_pkg;

    typedef enum logic [2:0] {
        OP_RX_OK            = 3'd0,
        OP_RX_BAD           = 3'd1,
        OP_TX_PACKET        = 3'd2,
        OP_RX_INCOMPLETE    = 3'd3,
        OP_LISTEN_TIMEOUT   = 3'd4,
        OP_TX_TRIGGER_FAIL  = 3'd5,
        OP_READ_COUNTER     = 3'd6
    } t_op;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LOSS_TURNS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE_SEQ   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_METADATA_LEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN         = 3'd4;

    localparam int unsigned NUM_COUNTERS = 9;
    localparam logic [3:0] CNT_LOST   = 4'd0;
    localparam logic [3:0] CNT_B1     = 4'd1;
    localparam logic [3:0] CNT_B2     = 4'd2;
    localparam logic [3:0] CNT_B34    = 4'd3;
    localparam logic [3:0] CNT_B5     = 4'd4;
    localparam logic [3:0] CNT_MAX    = 4'd5;
    localparam logic [3:0] CNT_OUTAGE = 4'd6;
    localparam logic [3:0] CNT_RXINC  = 4'd7;
    localparam logic [3:0] CNT_TXFAIL = 4'd8;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  packet_length;
        logic [15:0] sequence_req;
        logic [3:0]  counter_index;
    } t_in;

    typedef struct packed {
        logic        in_service;
        logic        length_ok;
        logic        forwarded;
        logic [14:0] gap;
        logic [15:0] tx_sequence;
        logic        tx_assigned;
        logic        outage;
        logic [31:0] counter_value;
    } t_out;

    typedef struct packed {
        logic [7:0]  sync_loss_turns;
        logic [15:0] keepalive_seq;
        logic [7:0]  keepalive_len;
        logic [7:0]  metadata_len;
        logic [7:0]  max_len;
    } t_cfg;

    // statistics events of one committed item
    typedef struct packed {
        logic        gap_hit;
        logic [14:0] gap;
        logic        outage;
        logic        rx_incomplete;
        logic        tx_fail;
        logic        rd_en;
        logic [3:0]  rd_index;
    } t_stat_evt;

endpackage

// ===== hw/rtl/slsm_cfg.sv =====
// configuration registers of the link session loss monitor
module slsm_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [slsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [slsm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output slsm_pkg::t_cfg                      o_cfg
);

    slsm_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_loss_turns <= 8'd8;
            r_cfg.keepalive_seq   <= 16'hFFFF;
            r_cfg.keepalive_len   <= 8'd4;
            r_cfg.metadata_len    <= 8'd3;
            r_cfg.max_len         <= 8'd255;
        end else if (i_cfg_valid) begin
            // unknown indexes are dropped
            if (i_cfg_index == slsm_pkg::CFG_SYNC_LOSS_TURNS) begin
                r_cfg.sync_loss_turns <= i_cfg_data[7:0];
            end
            if (i_cfg_index == slsm_pkg::CFG_KEEPALIVE_SEQ) begin
                r_cfg.keepalive_seq <= i_cfg_data[15:0];
            end
            if (i_cfg_index == slsm_pkg::CFG_KEEPALIVE_LEN) begin
                r_cfg.keepalive_len <= i_cfg_data[7:0];
            end
            if (i_cfg_index == slsm_pkg::CFG_METADATA_LEN) begin
                r_cfg.metadata_len <= i_cfg_data[7:0];
            end
            if (i_cfg_index == slsm_pkg::CFG_MAX_LEN) begin
                r_cfg.max_len <= i_cfg_data[7:0];
            end
        end
    end

endmodule

// ===== hw/rtl/slsm_session.sv =====
// session state, sequence tracking and per-item result of the monitor
module slsm_session (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_commit,
    input  slsm_pkg::t_in        i_item,
    input  slsm_pkg::t_cfg       i_cfg,
    output slsm_pkg::t_out       o_res,
    output slsm_pkg::t_stat_evt  o_evt
);

    logic        r_service_on;
    logic [7:0]  r_miss_count;
    logic [15:0] r_next_tx;
    logic [15:0] r_last_rx;
    logic        r_have_last_rx;

    logic        n_service_on;
    logic [7:0]  n_miss_count;
    logic [15:0] n_next_tx;
    logic [15:0] n_last_rx;
    logic        n_have_last_rx;

    logic        len_valid;
    logic        keep;
    logic [15:0] expect_rx;
    logic [15:0] tx_adv;
    logic [15:0] delta;
    logic        gap_hit;
    logic [7:0]  miss_inc;

    // next number, stepping over the keepalive number
    function automatic logic [15:0] advance(input logic [15:0] n, input logic [15:0] ka);
        logic [15:0] n1;
        n1 = n + 16'd1;
        if (n1 == ka) begin
            n1 = n1 + 16'd1;
        end
        return n1;
    endfunction

    assign len_valid = (i_item.packet_length > i_cfg.metadata_len)
                    && (i_item.packet_length <= i_cfg.max_len);
    assign keep      = (i_item.packet_length == i_cfg.keepalive_len)
                    && (i_item.sequence_req == i_cfg.keepalive_seq);
    assign expect_rx = advance(r_last_rx, i_cfg.keepalive_seq);
    assign tx_adv    = advance(r_next_tx, i_cfg.keepalive_seq);
    assign delta     = i_item.sequence_req - expect_rx;
    assign gap_hit   = r_have_last_rx && (delta != 16'd0) && !delta[15];
    assign miss_inc  = r_miss_count + 8'd1;

    always_comb begin
        n_service_on   = r_service_on;
        n_miss_count   = r_miss_count;
        n_next_tx      = r_next_tx;
        n_last_rx      = r_last_rx;
        n_have_last_rx = r_have_last_rx;
        o_res          = '0;
        o_evt          = '0;
        o_evt.rd_index = i_item.counter_index;

        unique case (slsm_pkg::t_op'(i_item.operation))
            slsm_pkg::OP_RX_OK: begin
                if (len_valid) begin
                    o_res.length_ok = 1'b1;
                    n_miss_count    = 8'd0;
                    n_service_on    = 1'b1;
                    if (!keep) begin
                        o_res.forwarded = 1'b1;
                        if (gap_hit) begin
                            o_res.gap     = delta[14:0];
                            o_evt.gap_hit = 1'b1;
                            o_evt.gap     = delta[14:0];
                        end
                        n_last_rx      = i_item.sequence_req;
                        n_have_last_rx = 1'b1;
                    end
                end
            end
            slsm_pkg::OP_RX_BAD: begin
                n_miss_count = 8'd0;
            end
            slsm_pkg::OP_TX_PACKET: begin
                if (len_valid) begin
                    o_res.length_ok   = 1'b1;
                    o_res.tx_assigned = 1'b1;
                    o_res.tx_sequence = r_next_tx;
                    n_next_tx         = tx_adv;
                end
            end
            slsm_pkg::OP_RX_INCOMPLETE: begin
                o_evt.rx_incomplete = 1'b1;
                n_miss_count        = 8'd0;
            end
            slsm_pkg::OP_LISTEN_TIMEOUT: begin
                if (r_service_on) begin
                    if (miss_inc >= i_cfg.sync_loss_turns) begin
                        o_res.outage   = 1'b1;
                        o_evt.outage   = 1'b1;
                        n_service_on   = 1'b0;
                        n_miss_count   = 8'd0;
                        n_have_last_rx = 1'b0;
                    end else begin
                        n_miss_count = miss_inc;
                    end
                end
            end
            slsm_pkg::OP_TX_TRIGGER_FAIL: begin
                o_evt.tx_fail  = 1'b1;
                o_res.outage   = r_service_on;
                o_evt.outage   = r_service_on;
                n_service_on   = 1'b0;
                n_miss_count   = 8'd0;
                n_have_last_rx = 1'b0;
            end
            slsm_pkg::OP_READ_COUNTER: begin
                o_evt.rd_en = 1'b1;
            end
            default: begin
            end
        endcase

        o_res.in_service = n_service_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_service_on   <= 1'b0;
            r_miss_count   <= 8'd0;
            r_next_tx      <= 16'd0;
            r_last_rx      <= 16'd0;
            r_have_last_rx <= 1'b0;
        end else if (i_commit) begin
            r_service_on   <= n_service_on;
            r_miss_count   <= n_miss_count;
            r_next_tx      <= n_next_tx;
            r_last_rx      <= n_last_rx;
            r_have_last_rx <= n_have_last_rx;
        end
    end

endmodule

// ===== hw/rtl/slsm_stats.sv =====
// statistics counters and counter read of the monitor
module slsm_stats (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_commit,
    input  slsm_pkg::t_stat_evt  i_evt,
    output logic [31:0]          o_rd_value
);

    logic [31:0] r_cnt [slsm_pkg::NUM_COUNTERS];
    logic [31:0] gap_ext;
    logic [3:0]  bin;

    assign gap_ext = {17'd0, i_evt.gap};

    always_comb begin
        priority if (i_evt.gap == 15'd1) begin
            bin = slsm_pkg::CNT_B1;
        end else if (i_evt.gap == 15'd2) begin
            bin = slsm_pkg::CNT_B2;
        end else if (i_evt.gap <= 15'd4) begin
            bin = slsm_pkg::CNT_B34;
        end else begin
            bin = slsm_pkg::CNT_B5;
        end
    end

    assign o_rd_value = (i_evt.rd_en && (i_evt.rd_index < 4'(slsm_pkg::NUM_COUNTERS)))
                      ? r_cnt[i_evt.rd_index] : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < slsm_pkg::NUM_COUNTERS; k++) begin
                r_cnt[k] <= 32'd0;
            end
        end else if (i_commit) begin
            if (i_evt.gap_hit) begin
                r_cnt[slsm_pkg::CNT_LOST] <= r_cnt[slsm_pkg::CNT_LOST] + gap_ext;
                r_cnt[bin]                <= r_cnt[bin] + 32'd1;
                if (gap_ext > r_cnt[slsm_pkg::CNT_MAX]) begin
                    r_cnt[slsm_pkg::CNT_MAX] <= gap_ext;
                end
            end
            if (i_evt.outage) begin
                r_cnt[slsm_pkg::CNT_OUTAGE] <= r_cnt[slsm_pkg::CNT_OUTAGE] + 32'd1;
            end
            if (i_evt.rx_incomplete) begin
                r_cnt[slsm_pkg::CNT_RXINC] <= r_cnt[slsm_pkg::CNT_RXINC] + 32'd1;
            end
            if (i_evt.tx_fail) begin
                r_cnt[slsm_pkg::CNT_TXFAIL] <= r_cnt[slsm_pkg::CNT_TXFAIL] + 32'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/link_session_loss_monitor_core.sv =====
// top level of the link session loss monitor
// Radio link session monitor. Each input transaction carries one radio event
// (rx ok, rx bad, tx packet, rx incomplete, listen timeout, tx trigger failed,
// counter read) and yields exactly one result transaction with the service
// state, length check, forward flag, sequence gap, assigned tx number, outage
// flag and, on a counter read, the selected 32-bit statistics counter.
// An event is captured in an input register, the whole state update is done
// in one pass of logic, and the result lands in an output register: one
// transaction per clock sustained while the receiver does not stall. The
// session registers and the nine counters update in that single pass, which
// sets the rate. Configuration writes are taken at any time (ready is always
// high) and should only be issued while the block is idle.
module link_session_loss_monitor_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input transactions
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  slsm_pkg::t_in                       i_in_data,
    // result transactions
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output slsm_pkg::t_out                      o_out_data,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [slsm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [slsm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    slsm_pkg::t_cfg      cfg;
    slsm_pkg::t_out      sess_res;
    slsm_pkg::t_out      res;
    slsm_pkg::t_stat_evt evt;
    logic [31:0]         cnt_value;

    logic                r_in_valid;
    slsm_pkg::t_in       r_in;
    logic                r_out_valid;
    slsm_pkg::t_out      r_out;

    logic                advance;
    logic                in_take;

    // the held event moves on when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    slsm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // session state and per-event decisions, committed only on advance
    slsm_session u_session (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_res    (sess_res),
        .o_evt    (evt)
    );

    // counters see the same commit so reads reflect all earlier events
    slsm_stats u_stats (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_commit   (advance),
        .i_evt      (evt),
        .o_rd_value (cnt_value)
    );

    always_comb begin
        res               = sess_res;
        res.counter_value = cnt_value;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

endmodule

// ===== hw/rtl/slsm_checker.sv =====
// port-level checks of the link session loss monitor, bound to the top level
`include "assert_macros.svh"

module slsm_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            o_out_valid,
    input  logic            i_out_ready,
    input  slsm_pkg::t_out  o_out_data
);

    // a stalled result holds
    `SLSM_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))

    // a tx number is only given to a packet of valid length
    `SLSM_ASSERT(a_tx_len, i_clk, i_rst_n, o_out_valid && o_out_data.tx_assigned |-> o_out_data.length_ok)

    // a forwarded packet has valid length and puts the link in service
    `SLSM_ASSERT(a_fwd_svc, i_clk, i_rst_n, o_out_valid && o_out_data.forwarded |-> o_out_data.length_ok && o_out_data.in_service)

    // an outage leaves the link out of service
    `SLSM_ASSERT(a_outage_off, i_clk, i_rst_n, o_out_valid && o_out_data.outage |-> !o_out_data.in_service)

    // a gap is only reported on a forwarded packet
    `SLSM_ASSERT(a_gap_fwd, i_clk, i_rst_n, o_out_valid && (o_out_data.gap != 15'd0) |-> o_out_data.forwarded)

endmodule

bind link_session_loss_monitor_core slsm_checker u_slsm_checker (.*);

// ===== sim/tb_link_session_loss_monitor_core.sv =====
// testbench of the link session loss monitor: random and directed radio events checked against a scoreboard
module tb_link_session_loss_monitor_core;
    import slsm_pkg::*;

    // operation code the block must treat as a no-op
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 400000;

    // expected session behavior, kept in step with accepted transactions
    class session_scoreboard;
        t_cfg        cfg;
        logic        svc_on;
        logic [7:0]  misses;
        logic [15:0] tx_next;
        logic [15:0] rx_last;
        logic        rx_seen;
        logic [31:0] stats [NUM_COUNTERS];
        t_out        pending_q [$];
        int          mismatches;

        function new();
            cfg.sync_loss_turns = 8'd8;
            cfg.keepalive_seq   = 16'hFFFF;
            cfg.keepalive_len   = 8'd4;
            cfg.metadata_len    = 8'd3;
            cfg.max_len         = 8'd255;
            svc_on  = 1'b0;
            misses  = '0;
            tx_next = '0;
            rx_last = '0;
            rx_seen = 1'b0;
            foreach (stats[i]) stats[i] = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SYNC_LOSS_TURNS: cfg.sync_loss_turns = data[7:0];
                CFG_KEEPALIVE_SEQ:   cfg.keepalive_seq   = data;
                CFG_KEEPALIVE_LEN:   cfg.keepalive_len   = data[7:0];
                CFG_METADATA_LEN:    cfg.metadata_len    = data[7:0];
                CFG_MAX_LEN:         cfg.max_len         = data[7:0];
                default: ;
            endcase
        endfunction

        // next sequence number, stepping over the keepalive number
        function logic [15:0] next_number(logic [15:0] n);
            logic [15:0] m;
            m = n + 16'd1;
            if (m == cfg.keepalive_seq) m = m + 16'd1;
            return m;
        endfunction

        function void note_burst(logic [15:0] n);
            if (n == 16'd1)
                stats[CNT_B1] += 32'd1;
            else if (n == 16'd2)
                stats[CNT_B2] += 32'd1;
            else if (n <= 16'd4)
                stats[CNT_B34] += 32'd1;
            else
                stats[CNT_B5] += 32'd1;
            if (32'(n) > stats[CNT_MAX]) stats[CNT_MAX] = 32'(n);
        endfunction

        function logic drop_service();
            logic was_on;
            was_on = svc_on;
            if (was_on) stats[CNT_OUTAGE] += 32'd1;
            svc_on  = 1'b0;
            misses  = '0;
            rx_seen = 1'b0;
            return was_on;
        endfunction

        function void note_input(t_in item);
            t_out        r;
            logic        len_good;
            logic [15:0] want_seq;
            logic [15:0] delta;
            r = '0;
            len_good = (item.packet_length > cfg.metadata_len) &&
                       (item.packet_length <= cfg.max_len);
            case (item.operation)
                OP_RX_OK: begin
                    if (len_good) begin
                        r.length_ok = 1'b1;
                        misses = '0;
                        svc_on = 1'b1;
                        // keepalive keeps service up but skips numbering
                        if (!(item.packet_length == cfg.keepalive_len &&
                              item.sequence_req == cfg.keepalive_seq)) begin
                            r.forwarded = 1'b1;
                            if (rx_seen) begin
                                want_seq = next_number(rx_last);
                                delta = item.sequence_req - want_seq;
                                // only forward distance below half the space is a loss
                                if (delta != 16'd0 && delta < 16'h8000) begin
                                    r.gap = delta[14:0];
                                    stats[CNT_LOST] += 32'(delta);
                                    note_burst(delta);
                                end
                            end
                            rx_last = item.sequence_req;
                            rx_seen = 1'b1;
                        end
                    end
                end
                OP_RX_BAD: misses = '0;
                OP_TX_PACKET: begin
                    if (len_good) begin
                        r.length_ok   = 1'b1;
                        r.tx_assigned = 1'b1;
                        r.tx_sequence = tx_next;
                        tx_next = next_number(tx_next);
                    end
                end
                OP_RX_INCOMPLETE: begin
                    stats[CNT_RXINC] += 32'd1;
                    misses = '0;
                end
                OP_LISTEN_TIMEOUT: begin
                    if (svc_on) begin
                        misses = misses + 8'd1;
                        if (misses >= cfg.sync_loss_turns) r.outage = drop_service();
                    end
                end
                OP_TX_TRIGGER_FAIL: begin
                    stats[CNT_TXFAIL] += 32'd1;
                    r.outage = drop_service();
                end
                OP_READ_COUNTER: begin
                    if (item.counter_index < NUM_COUNTERS) r.counter_value = stats[item.counter_index];
                end
                default: ;
            endcase
            r.in_service = svc_on;
            pending_q.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] error: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(t_out got);
            t_out want;
            if (pending_q.size() == 0) begin
                report("result transaction with nothing pending");
            end else begin
                want = pending_q.pop_front();
                compare_field("in_service", 32'(got.in_service), 32'(want.in_service));
                compare_field("length_ok", 32'(got.length_ok), 32'(want.length_ok));
                compare_field("forwarded", 32'(got.forwarded), 32'(want.forwarded));
                compare_field("gap", 32'(got.gap), 32'(want.gap));
                compare_field("tx_sequence", 32'(got.tx_sequence), 32'(want.tx_sequence));
                compare_field("tx_assigned", 32'(got.tx_assigned), 32'(want.tx_assigned));
                compare_field("outage", 32'(got.outage), 32'(want.outage));
                compare_field("counter_value", got.counter_value, want.counter_value);
            end
        endtask
    endclass

    // clock, reset and block ports
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    session_scoreboard sb = new();

    // stimulus side state
    t_cfg        stim_cfg;
    logic [15:0] gen_last_seq;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          cycle_count = 0;
    t_cfg        c;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    link_session_loss_monitor_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // sample all three channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
            if (i_in_valid && o_in_ready) sb.note_input(i_in_data);
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // receiver stalls at random, per phase
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic send_item(t_in item);
        @(negedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending and wait for every pending result, plus pipeline slack
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_in make_in(logic [2:0] op, logic [7:0] len, logic [15:0] seq,
                                    logic [3:0] idx);
        t_in it;
        it.operation     = op;
        it.packet_length = len;
        it.sequence_req  = seq;
        it.counter_index = idx;
        return it;
    endfunction

    // mostly valid lengths, some keepalive lengths, some noise
    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 85 && stim_cfg.metadata_len < stim_cfg.max_len)
            return 8'($urandom_range(32'(stim_cfg.metadata_len) + 1, 32'(stim_cfg.max_len)));
        else if (r < 90)
            return stim_cfg.keepalive_len;
        return 8'($urandom_range(0, 255));
    endfunction

    // sequence number relative to the next expected one
    function automatic logic [15:0] pick_seq();
        int          r;
        logic [15:0] d;
        r = $urandom_range(99);
        if (r < 45) d = 16'd0;
        else if (r < 55) d = 16'd1;
        else if (r < 63) d = 16'd2;
        else if (r < 71) d = 16'($urandom_range(3, 4));
        else if (r < 81) d = 16'($urandom_range(5, 64));
        else if (r < 86) d = 16'($urandom_range(65, 32767));
        else if (r < 93) d = 16'($urandom_range(32768, 65535));
        else if (r < 96) return gen_last_seq;
        else return 16'($urandom);
        return sb.next_number(gen_last_seq) + d;
    endfunction

    function automatic t_in build_item(logic [2:0] op);
        t_in it;
        it.operation     = op;
        it.packet_length = pick_length();
        it.sequence_req  = 16'($urandom);
        it.counter_index = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15))
                                                    : 4'($urandom_range(0, 8));
        if (op == OP_RX_OK) begin
            if ($urandom_range(99) < 8) begin
                it.packet_length = stim_cfg.keepalive_len;
                it.sequence_req  = stim_cfg.keepalive_seq;
            end else begin
                it.sequence_req = pick_seq();
                gen_last_seq    = it.sequence_req;
            end
        end
        return it;
    endfunction

    function automatic logic [2:0] random_op();
        int r;
        r = $urandom_range(99);
        if (r < 40) return OP_RX_OK;
        if (r < 45) return OP_RX_BAD;
        if (r < 60) return OP_TX_PACKET;
        if (r < 64) return OP_RX_INCOMPLETE;
        if (r < 80) return OP_LISTEN_TIMEOUT;
        if (r < 83) return OP_TX_TRIGGER_FAIL;
        if (r < 97) return OP_READ_COUNTER;
        return OP_UNUSED;
    endfunction

    // one phase: reconfigure while idle, then random traffic
    task automatic run_phase(t_cfg cfg_set, int send_pct, int stall_pct, int n_items);
        int sent;
        int burst;
        wait_drained();
        write_cfg(CFG_SYNC_LOSS_TURNS, {8'd0, cfg_set.sync_loss_turns});
        write_cfg(CFG_KEEPALIVE_SEQ, cfg_set.keepalive_seq);
        write_cfg(CFG_KEEPALIVE_LEN, {8'd0, cfg_set.keepalive_len});
        write_cfg(CFG_METADATA_LEN, {8'd0, cfg_set.metadata_len});
        write_cfg(CFG_MAX_LEN, {8'd0, cfg_set.max_len});
        stim_cfg       = cfg_set;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 6) begin
                // a run of missed listen turns, long enough to end service for thresholds up to 16
                burst = (cfg_set.sync_loss_turns <= 8'd16) ? int'(cfg_set.sync_loss_turns) + 1
                                                           : int'($urandom_range(1, 16));
                send_item(build_item(OP_RX_OK));
                repeat (burst) send_item(build_item(OP_LISTEN_TIMEOUT));
                sent += burst + 1;
            end else begin
                send_item(build_item(random_op()));
                sent++;
            end
        end
    endtask

    initial begin
        stim_cfg     = sb.cfg;
        gen_last_seq = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset configuration
        send_item(make_in(OP_LISTEN_TIMEOUT, 8'd10, 16'd0, 4'd0));   // out of service
        send_item(make_in(OP_READ_COUNTER, 8'd0, 16'd0, 4'd15));     // index beyond range
        send_item(make_in(OP_UNUSED, 8'd255, 16'hFFFF, 4'd15));
        send_item(make_in(OP_TX_PACKET, 8'd3, 16'd0, 4'd0));         // too short
        send_item(make_in(OP_TX_PACKET, 8'd4, 16'd0, 4'd0));
        send_item(make_in(OP_TX_PACKET, 8'd255, 16'd0, 4'd0));
        send_item(make_in(OP_RX_OK, 8'd3, 16'd100, 4'd0));           // invalid rx length
        send_item(make_in(OP_RX_OK, 8'd255, 16'd100, 4'd0));         // first number
        send_item(make_in(OP_RX_OK, 8'd4, 16'hFFFF, 4'd0));          // keepalive
        send_item(make_in(OP_RX_OK, 8'd10, 16'd101, 4'd0));
        send_item(make_in(OP_RX_OK, 8'd10, 16'd101, 4'd0));          // repeated number
        send_item(make_in(OP_RX_OK, 8'd10, 16'd103, 4'd0));          // one lost
        send_item(make_in(OP_RX_OK, 8'd10, 16'h8068, 4'd0));         // exactly half space
        send_item(make_in(OP_RX_OK, 8'd10, 16'h0068, 4'd0));         // largest forward gap
        send_item(make_in(OP_RX_OK, 8'd10, 16'd65534, 4'd0));        // backward
        send_item(make_in(OP_RX_OK, 8'd10, 16'd0, 4'd0));            // skips keepalive number
        send_item(make_in(OP_RX_OK, 8'd4, 16'd5, 4'd0));             // keepalive length only
        send_item(make_in(OP_TX_TRIGGER_FAIL, 8'd0, 16'd0, 4'd0));   // drops service
        send_item(make_in(OP_TX_TRIGGER_FAIL, 8'd0, 16'd0, 4'd0));   // already out
        send_item(make_in(OP_RX_OK, 8'd20, 16'd200, 4'd0));
        repeat (8) send_item(make_in(OP_LISTEN_TIMEOUT, 8'd0, 16'd0, 4'd0));
        send_item(make_in(OP_READ_COUNTER, 8'd0, 16'd0, CNT_MAX));
        gen_last_seq = 16'd200;

        // random phases over several configurations and idling patterns
        c = '{sync_loss_turns: 8'd1, keepalive_seq: 16'd0, keepalive_len: 8'd0,
              metadata_len: 8'd0, max_len: 8'd255};
        run_phase(c, 0, 0, 120);
        wait_drained();
        // keepalive number just ahead of the tx numbering
        c = '{sync_loss_turns: 8'd8, keepalive_seq: sb.tx_next + 16'd2, keepalive_len: 8'd4,
              metadata_len: 8'd3, max_len: 8'd255};
        run_phase(c, 75, 0, 120);
        c = '{sync_loss_turns: 8'd255, keepalive_seq: 16'h8000, keepalive_len: 8'd255,
              metadata_len: 8'd254, max_len: 8'd255};
        run_phase(c, 0, 75, 100);
        // zero threshold: first timeout in service ends it
        c = '{sync_loss_turns: 8'd0, keepalive_seq: 16'd12345, keepalive_len: 8'd20,
              metadata_len: 8'd10, max_len: 8'd40};
        run_phase(c, 27, 27, 120);
        // no length is valid
        c = '{sync_loss_turns: 8'd3, keepalive_seq: 16'd65534, keepalive_len: 8'd8,
              metadata_len: 8'd255, max_len: 8'd0};
        run_phase(c, 0, 0, 40);
        c = '{sync_loss_turns: 8'd4, keepalive_seq: 16'hFFFF, keepalive_len: 8'd255,
              metadata_len: 8'd0, max_len: 8'd255};
        run_phase(c, 27, 27, 150);
        c = '{sync_loss_turns: 8'd8, keepalive_seq: 16'hFFFF, keepalive_len: 8'd4,
              metadata_len: 8'd3, max_len: 8'd255};
        run_phase(c, 75, 0, 150);
        // keepalive number just ahead of the rx numbering
        c = '{sync_loss_turns: 8'd16, keepalive_seq: gen_last_seq + 16'd3,
              keepalive_len: 8'($urandom_range(8, 200)), metadata_len: 8'd7, max_len: 8'd200};
        run_phase(c, 0, 75, 130);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
